// File: hw/rtl/bdgf_pkg.sv
// Shared types and constants for the bitmap diagonal gap filler.
// No dependencies; the interfaces and all modules use it.
package bdgf_pkg;

    localparam int MAX_ROW_WIDTH  = 64;
    localparam int ROW_WIDTH_W    = 7;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    typedef logic [MAX_ROW_WIDTH-1:0] t_row;
    typedef logic [ROW_WIDTH_W-1:0]   t_row_width;

    typedef struct packed {
        t_row pixels;
        logic last;
    } t_out_item;

    // Up to two result items written to the output queue in one cycle, in order.
    typedef struct packed {
        logic      v0;
        t_out_item d0;
        logic      v1;
        t_out_item d1;
    } t_push;

endpackage

// File: hw/rtl/bdgf_row_if.sv
// Input row channel: valid/ready handshake with a pixel row and end-of-frame flag.
// Depends on bdgf_pkg.
interface bdgf_row_if;
    logic          valid;
    logic          ready;
    bdgf_pkg::t_row row_pixels;
    logic          end_of_frame;

    modport source (output valid, output row_pixels, output end_of_frame, input ready);
    modport sink   (input valid, input row_pixels, input end_of_frame, output ready);
endinterface

// File: hw/rtl/bdgf_out_if.sv
// Output row channel: valid/ready handshake with a smoothed row and frame-last flag.
// Depends on bdgf_pkg.
interface bdgf_out_if;
    logic          valid;
    logic          ready;
    bdgf_pkg::t_row out_pixels;
    logic          frame_last;

    modport source (output valid, output out_pixels, output frame_last, input ready);
    modport sink   (input valid, input out_pixels, input frame_last, output ready);
endinterface

// File: hw/rtl/bdgf_window.sv
// Diagonal fill logic for one pair of adjacent rows, all windows in parallel.
// Depends on bdgf_pkg.
module bdgf_window (
    input  bdgf_pkg::t_row       i_top,
    input  bdgf_pkg::t_row       i_bot,
    input  bdgf_pkg::t_row_width i_row_width,
    output bdgf_pkg::t_row       o_top_add,
    output bdgf_pkg::t_row       o_bot_add
);

    bdgf_pkg::t_row_width w_sat;
    bdgf_pkg::t_row       mask;
    bdgf_pkg::t_row       top_right;
    bdgf_pkg::t_row       bot_right;
    bdgf_pkg::t_row       rising;
    bdgf_pkg::t_row       falling;

    assign w_sat = (i_row_width > bdgf_pkg::t_row_width'(bdgf_pkg::MAX_ROW_WIDTH))
                 ? bdgf_pkg::t_row_width'(bdgf_pkg::MAX_ROW_WIDTH) : i_row_width;

    // bit p is the left pixel of a window for p in 1 .. width-1
    always_comb begin
        for (int i = 0; i < bdgf_pkg::MAX_ROW_WIDTH; i++) begin
            mask[i] = (i >= 1) && (bdgf_pkg::t_row_width'(i) < w_sat);
        end
    end

    assign top_right = i_top << 1;
    assign bot_right = i_bot << 1;
    assign rising    = top_right & i_bot & ~i_top & ~bot_right & mask;
    assign falling   = i_top & bot_right & ~top_right & ~i_bot & mask;
    assign o_top_add = rising | (falling >> 1);
    assign o_bot_add = (rising >> 1) | falling;

endmodule

// File: hw/rtl/bdgf_out_fifo.sv
// Small result queue: takes up to two items a cycle, drives the output channel.
// Depends on bdgf_pkg and bdgf_out_if.
module bdgf_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdgf_pkg::t_push     i_push,
    output logic                o_room2,
    bdgf_out_if.source          o_out
);

    bdgf_pkg::t_out_item                     r_mem [bdgf_pkg::OUT_FIFO_DEPTH];
    logic [bdgf_pkg::OUT_PTR_W-1:0]          r_wp, n_wp;
    logic [bdgf_pkg::OUT_PTR_W-1:0]          r_rp, n_rp;
    logic [bdgf_pkg::OUT_CNT_W-1:0]          r_count, n_count;
    logic [1:0]                              nwr;
    logic                                    pop;
    logic [bdgf_pkg::OUT_PTR_W-1:0]          wp1;

    assign nwr  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign pop  = o_out.valid && o_out.ready;
    assign wp1  = r_wp + bdgf_pkg::OUT_PTR_W'(1);

    assign o_out.valid      = (r_count != '0);
    assign o_out.out_pixels = r_mem[r_rp].pixels;
    assign o_out.frame_last = r_mem[r_rp].last;
    assign o_room2 = (r_count <= bdgf_pkg::OUT_CNT_W'(bdgf_pkg::OUT_FIFO_DEPTH - 2));

    always_comb begin
        n_wp    = r_wp + bdgf_pkg::OUT_PTR_W'(nwr);
        n_rp    = pop ? r_rp + bdgf_pkg::OUT_PTR_W'(1) : r_rp;
        n_count = r_count + bdgf_pkg::OUT_CNT_W'(nwr) - bdgf_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // payload storage, compacted in order
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.d0;
            if (i_push.v1) begin
                r_mem[wp1] <= i_push.d1;
            end
        end else if (i_push.v1) begin
            r_mem[r_wp] <= i_push.d1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdgf_pkg::OUT_CNT_W'(bdgf_pkg::OUT_FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 || i_push.v1) |-> o_room2)
        else $error("push without room for two items");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.v0 && !i_push.v1) |=> r_count == $past(r_count) - 1'b1)
        else $error("count did not drop on pop");

endmodule

// File: hw/rtl/bitmap_diagonal_gap_fill.sv
// Top level of the bitmap diagonal gap filler.
// Depends on bdgf_pkg, bdgf_row_if, bdgf_out_if, bdgf_window, bdgf_out_fifo.

// Smooths a one-bit bitmap streamed one row per item (pixel x at bit
// row_width-1-x). In every 2x2 window of two adjacent rows where exactly one
// diagonal is set and the other is clear, the clear diagonal is filled; all
// decisions read original pixels only. Each row leaves one item later, once
// the row below it has arrived; a row flagged end_of_frame leaves right after
// the held row, with frame_last set, and the frame restarts, so that item
// gives two results when a row is held. Bits above row_width pass unchanged;
// widths above 64 act as 64. Rate: one row accepted per cycle while the input
// register can advance. An accepted row waits in the input register, then the
// window logic writes its results into a four-entry result queue; the input
// register advances only while the queue has room for two items.
// row_width is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module bitmap_diagonal_gap_fill (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  bdgf_pkg::t_row_width  i_cfg_wdata,
    bdgf_row_if.sink              i_row,
    bdgf_out_if.source            o_row
);

    // configuration
    bdgf_pkg::t_row_width r_row_width;

    // input register
    logic           r_s1_valid;
    bdgf_pkg::t_row r_s1_pixels;
    logic           r_s1_eof;

    // frame state: the row waiting for its lower neighbor
    logic           r_pending;
    bdgf_pkg::t_row r_held_orig;
    bdgf_pkg::t_row r_held_smooth;

    bdgf_pkg::t_row  top_add;
    bdgf_pkg::t_row  bot_add;
    bdgf_pkg::t_row  cur_smooth;
    bdgf_pkg::t_push push;
    logic            room2;
    logic            s1_fire;
    logic            in_fire;

    assign s1_fire     = r_s1_valid && room2;
    assign i_row.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_row.valid && i_row.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= bdgf_pkg::t_row_width'(bdgf_pkg::MAX_ROW_WIDTH);
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_row.ready) begin
            r_s1_valid <= i_row.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixels <= i_row.row_pixels;
            r_s1_eof    <= i_row.end_of_frame;
        end
    end

    bdgf_window u_window (
        .i_top       (r_held_orig),
        .i_bot       (r_s1_pixels),
        .i_row_width (r_row_width),
        .o_top_add   (top_add),
        .o_bot_add   (bot_add)
    );

    // without a held row there is no window above the current one
    assign cur_smooth = r_pending ? (r_s1_pixels | bot_add) : r_s1_pixels;

    always_comb begin
        push.v0        = s1_fire && r_pending;
        push.d0.pixels = r_held_smooth | top_add;
        push.d0.last   = 1'b0;
        push.v1        = s1_fire && r_s1_eof;
        push.d1.pixels = cur_smooth;
        push.d1.last   = 1'b1;
    end

    // frame end flushes and clears; otherwise the current row becomes held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (s1_fire) begin
            r_pending <= !r_s1_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && !r_s1_eof) begin
            r_held_orig   <= r_s1_pixels;
            r_held_smooth <= cur_smooth;
        end
    end

    bdgf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_out   (o_row)
    );

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_pixels)
                                      && $stable(r_s1_eof)))
        else $error("stalled input row lost");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_eof) |=> !r_pending)
        else $error("frame end did not clear held row");

    a_row_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_s1_eof) |=> (r_pending && r_held_orig == $past(r_s1_pixels)))
        else $error("row not held for its lower neighbor");

endmodule

// File: bench/tb_bitmap_diagonal_gap_fill.sv
// Testbench for bitmap_diagonal_gap_fill: directed rows, then random frames checked by a predictor.
// Depends on bdgf_pkg, bdgf_row_if, bdgf_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_bitmap_diagonal_gap_fill;

    // Timing knobs
    localparam int SETTLE_CYCLES = 8;     // drain margin after the last owed row, covering queue slack
    localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int RANDOM_ROWS   = 1850;

    // n_typed value that means "take the expectation from the predictor"
    localparam int                  FROM_PREDICTOR = -1;
    localparam bdgf_pkg::t_out_item NO_ROW         = '0;

    typedef enum logic {
        STEP_ROW,
        STEP_WIDTH
    } t_step_kind;

    // One directed step. For STEP_WIDTH the width value rides in pixels.
    typedef struct {
        t_step_kind          kind;
        bdgf_pkg::t_row      pixels;
        logic                eof;
        int                  n_typed;
        bdgf_pkg::t_out_item res_a;
        bdgf_pkg::t_out_item res_b;
    } t_dir_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    bdgf_pkg::t_row_width i_cfg_wdata;

    bdgf_row_if row_ch ();
    bdgf_out_if out_ch ();

    bitmap_diagonal_gap_fill u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_row       (row_ch),
        .o_row       (out_ch)
    );

    // Predictor state: mirror of the block's held row and its width register
    bdgf_pkg::t_row       held_raw;
    bdgf_pkg::t_row       held_filled;
    bit                   row_held;
    bdgf_pkg::t_row_width width_now;

    // Smoothed rows still owed by the block, oldest first
    bdgf_pkg::t_out_item  due_rows [$];
    int                   mismatches;
    int                   idle_cycles;

    // Directed rows. Expectations are typed in only where they are obvious:
    // single-row frames, lone diagonals at either edge, checkerboards, vertical
    // pairs, width two, and the widths at or below one (pass-through) or above 64 (acts as 64).
    t_dir_step dir_steps [30] = '{
        // single-row frames pass unchanged with frame_last set
        '{STEP_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1,
          {64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, NO_ROW},
        '{STEP_ROW, 64'h0, 1'b1, 1, {64'h0, 1'b1}, NO_ROW},
        // falling diagonal at pixel 0 -> both rows get pixels 0 and 1
        '{STEP_ROW, 64'h8000_0000_0000_0000, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h4000_0000_0000_0000, 1'b1, 2,
          {64'hC000_0000_0000_0000, 1'b0}, {64'hC000_0000_0000_0000, 1'b1}},
        // rising diagonal at pixel 0
        '{STEP_ROW, 64'h4000_0000_0000_0000, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h8000_0000_0000_0000, 1'b1, 2,
          {64'hC000_0000_0000_0000, 1'b0}, {64'hC000_0000_0000_0000, 1'b1}},
        // checkerboard: every window has one diagonal, everything fills
        '{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h5555_5555_5555_5555, 1'b0, 1,
          {64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, NO_ROW},
        '{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 2,
          {64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, {64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
        // vertical pairs: no diagonal, nothing fills
        '{STEP_ROW, 64'hC000_0000_0000_0000, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'hC000_0000_0000_0000, 1'b1, 2,
          {64'hC000_0000_0000_0000, 1'b0}, {64'hC000_0000_0000_0000, 1'b1}},
        // rising diagonal at the last pixel pair
        '{STEP_ROW, 64'h1, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h2, 1'b1, 2, {64'h3, 1'b0}, {64'h3, 1'b1}},
        // narrowest window; upper bits are noise and must pass through
        '{STEP_WIDTH, 64'd2, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'hFFFF_FFFF_FFFF_FFF9, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h2, 1'b1, 2,
          {64'hFFFF_FFFF_FFFF_FFFB, 1'b0}, {64'h3, 1'b1}},
        // width one and zero: no window at all
        '{STEP_WIDTH, 64'd1, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h2, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h1, 1'b1, 2, {64'h2, 1'b0}, {64'h1, 1'b1}},
        '{STEP_WIDTH, 64'd0, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h8000_0000_0000_0000, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h4000_0000_0000_0000, 1'b1, 2,
          {64'h8000_0000_0000_0000, 1'b0}, {64'h4000_0000_0000_0000, 1'b1}},
        // register maximum saturates to the full row
        '{STEP_WIDTH, 64'd127, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h8000_0000_0000_0000, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h4000_0000_0000_0000, 1'b1, 2,
          {64'hC000_0000_0000_0000, 1'b0}, {64'hC000_0000_0000_0000, 1'b1}},
        // width changed while a row is held: the pair uses the new width
        '{STEP_WIDTH, 64'd8, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h8000_0000_0000_0042, 1'b0, FROM_PREDICTOR, NO_ROW, NO_ROW},
        '{STEP_WIDTH, 64'd64, 1'b0, 0, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h4000_0000_0000_0081, 1'b0, FROM_PREDICTOR, NO_ROW, NO_ROW},
        '{STEP_ROW, 64'h8000_0000_0000_0104, 1'b1, FROM_PREDICTOR, NO_ROW, NO_ROW}
    };

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Smooth one incoming row against the held one; returns how many rows
    // leave the block for it (0, 1 or 2) and updates the held state.
    function automatic int fill_rows(input bdgf_pkg::t_row cur, input logic eof,
                                     output bdgf_pkg::t_out_item res [2]);
        int unsigned    w;
        bdgf_pkg::t_row win;
        bdgf_pkg::t_row up_right;
        bdgf_pkg::t_row dn_right;
        bdgf_pkg::t_row rising;
        bdgf_pkg::t_row falling;
        bdgf_pkg::t_row cur_filled;
        int             n;
        w   = (width_now > bdgf_pkg::MAX_ROW_WIDTH) ? bdgf_pkg::MAX_ROW_WIDTH : width_now;
        win = (w >= bdgf_pkg::MAX_ROW_WIDTH) ? '1
            : ((bdgf_pkg::t_row'(1) << w) - bdgf_pkg::t_row'(1));
        // bit p marks the window whose left pixel is bit p, right pixel bit p-1
        win &= ~bdgf_pkg::t_row'(1);
        n          = 0;
        cur_filled = cur;
        res[0]     = '0;
        res[1]     = '0;
        if (row_held) begin
            up_right = held_raw << 1;
            dn_right = cur << 1;
            // top-right + bottom-left set, the other diagonal clear
            rising  = up_right & cur & ~held_raw & ~dn_right & win;
            // top-left + bottom-right set, the other diagonal clear
            falling = held_raw & dn_right & ~up_right & ~cur & win;
            res[0]  = '{pixels: held_filled | rising | (falling >> 1), last: 1'b0};
            cur_filled = cur | (rising >> 1) | falling;
            n = 1;
        end
        if (eof) begin
            res[n]      = '{pixels: cur_filled, last: 1'b1};
            n++;
            held_raw    = '0;
            held_filled = '0;
            row_held    = 1'b0;
        end else begin
            held_raw    = cur;
            held_filled = cur_filled;
            row_held    = 1'b1;
        end
        return n;
    endfunction

    // Idle length: mostly none, often short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    // Offer one row, wait for it to be taken, then book its expected results.
    task automatic send_row(input bdgf_pkg::t_row px, input logic eof, input int n_typed,
                            input bdgf_pkg::t_out_item typed_a,
                            input bdgf_pkg::t_out_item typed_b,
                            input bit calm);
        bdgf_pkg::t_out_item res [2];
        int                  n;
        int                  gap;
        row_ch.valid        <= 1'b1;
        row_ch.row_pixels   <= px;
        row_ch.end_of_frame <= eof;
        @(posedge i_clk);
        while (row_ch.ready !== 1'b1) @(posedge i_clk);
        // predictor always runs so the held state stays in step
        n = fill_rows(px, eof, res);
        if (n_typed == FROM_PREDICTOR) begin
            for (int i = 0; i < n; i++) due_rows.push_back(res[i]);
        end else begin
            if (n_typed > 0) due_rows.push_back(typed_a);
            if (n_typed > 1) due_rows.push_back(typed_b);
        end
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed row is out, then let the pipe settle.
    // A held row produces nothing yet, so it owes no row and stays held.
    task automatic wait_drained();
        row_ch.valid <= 1'b0;
        while (due_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_row_width(input bdgf_pkg::t_row_width w);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        width_now   = w;
    endtask

    // Output side: ready in random bursts, with short and long stalls and
    // the occasional long stretch held high.
    initial begin
        int run;
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare each row leaving the block with the oldest expectation
    always @(posedge i_clk) begin : check_out
        bdgf_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_rows.size() == 0) begin
                $error("unexpected item: out_pixels=%h frame_last=%b",
                       out_ch.out_pixels, out_ch.frame_last);
                mismatches++;
            end else begin
                want = due_rows.pop_front();
                if (out_ch.out_pixels !== want.pixels) begin
                    $error("out_pixels: expected %h, got %h", want.pixels, out_ch.out_pixels);
                    mismatches++;
                end
                if (out_ch.frame_last !== want.last) begin
                    $error("frame_last: expected %b, got %b", want.last, out_ch.frame_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (row_ch.valid && row_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        t_dir_step            s;
        int                   rows_sent;
        int                   pick;
        int                   n_frames;
        int                   len;
        int                   r;
        int                   style;
        bit                   calm;
        bit                   cut;
        logic                 eof;
        bdgf_pkg::t_row       row;
        bdgf_pkg::t_row_width w;

        held_raw    = '0;
        held_filled = '0;
        row_held    = 1'b0;
        width_now   = bdgf_pkg::t_row_width'(bdgf_pkg::MAX_ROW_WIDTH);   // register reset value
        rows_sent   = 0;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        row_ch.valid        <= 1'b0;
        row_ch.row_pixels   <= '0;
        row_ch.end_of_frame <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset width first, then the corners of the width
        foreach (dir_steps[i]) begin
            s = dir_steps[i];
            if (s.kind == STEP_WIDTH) begin
                set_row_width(bdgf_pkg::t_row_width'(s.pixels));
            end else begin
                send_row(s.pixels, s.eof, s.n_typed, s.res_a, s.res_b, 1'b0);
            end
        end

        // Random phases: each may pick a new width, then sends a few frames.
        // Frames are mostly short; some rows carry a stray end_of_frame and
        // some phases stop mid-frame so the next width lands on a held row.
        while (rows_sent < RANDOM_ROWS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                case ($urandom_range(0, 7))
                    0: begin
                        w = 7'd2;
                    end
                    1: begin
                        w = bdgf_pkg::t_row_width'(bdgf_pkg::MAX_ROW_WIDTH);
                    end
                    2: begin
                        w = bdgf_pkg::t_row_width'($urandom_range(65, 127));
                    end
                    3: begin
                        w = bdgf_pkg::t_row_width'($urandom_range(0, 1));
                    end
                    default: begin
                        w = bdgf_pkg::t_row_width'($urandom_range(2, 64));
                    end
                endcase
                set_row_width(w);
            end else if (pick == 3) begin
                wait_drained();
            end

            calm     = ($urandom_range(0, 4) == 0);
            n_frames = $urandom_range(1, 5);
            for (int f = 0; f < n_frames; f++) begin
                r     = $urandom_range(0, 99);
                len   = (r < 80) ? $urandom_range(1, 6)
                      : (r < 95) ? $urandom_range(7, 20) : $urandom_range(21, 50);
                style = $urandom_range(0, 3);
                cut   = (f == n_frames - 1) && ($urandom_range(0, 6) == 0);
                row   = {$urandom, $urandom};
                for (int k = 0; k < len; k++) begin
                    case (style)
                        0: begin
                            row = {$urandom, $urandom};
                        end
                        1: begin
                            // sparse: isolated pixels, lone diagonals
                            row = {$urandom, $urandom} & {$urandom, $urandom}
                                & {$urandom, $urandom};
                        end
                        2: begin
                            row = {$urandom, $urandom} | {$urandom, $urandom};
                        end
                        default: begin
                            // slanted strokes: previous row shifted one pixel
                            row = ($urandom_range(0, 1) ? (row << 1) : (row >> 1))
                                ^ ({$urandom, $urandom} & {$urandom, $urandom}
                                 & {$urandom, $urandom} & {$urandom, $urandom});
                        end
                    endcase
                    eof = (k == len - 1) ? !cut : ($urandom_range(0, 39) == 0);
                    send_row(row, eof, FROM_PREDICTOR, NO_ROW, NO_ROW, calm);
                    rows_sent++;
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
